>>> rtl/mbc1_pkg.sv
// Shared types and constants for the MBC1 bank address mapper.
// Used by mbc1_map and by the top level mbc1_bank_address_mapper_unit; no other dependencies.
`default_nettype none

package mbc1_pkg;

	// Field widths fixed by the cartridge bus and the configuration registers.
	localparam int BUS_ADDR_W = 16;
	localparam int BYTE_W     = 8;
	localparam int MEM_ADDR_W = 21;
	localparam int ROM_SIZE_W = 24;
	localparam int RAM_SIZE_W = 18;
	localparam int ROM_BANK_W = 7;
	localparam int RAM_BANK_W = 2;
	localparam int RAM_OFF_W  = 15;

	// The value in the low nibble that enables cartridge RAM.
	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	// Result targets.
	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_ROM  = 2'd1,
		TGT_RAM  = 2'd2
	} target_t;

	// Controller register regions, selected by bus address bits 14:13 in the ROM window.
	typedef enum logic [1:0] {
		CTL_RAM_ENABLE = 2'd0,
		CTL_ROM_BANK   = 2'd1,
		CTL_UPPER_BITS = 2'd2,
		CTL_MODE       = 2'd3
	} ctl_region_t;

	// Configuration register indexes on the APB port.
	typedef enum logic [1:0] {
		REG_MBC1_PRESENT = 2'd0,
		REG_ROM_SIZE     = 2'd1,
		REG_RAM_SIZE     = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_index_t;

	// One bus access.
	typedef struct packed {
		logic                  action;
		logic [BUS_ADDR_W-1:0] bus_address;
		logic [BYTE_W-1:0]     bus_data;
	} item_t;

	// One translated result.
	typedef struct packed {
		target_t               target;
		logic [MEM_ADDR_W-1:0] mem_address;
		logic                  ram_write;
		logic [BYTE_W-1:0]     write_byte;
	} result_t;

	// Static cartridge configuration.
	typedef struct packed {
		logic                  mbc1_present;
		logic [ROM_SIZE_W-1:0] rom_size_bytes;
		logic [RAM_SIZE_W-1:0] ram_size_bytes;
	} cfg_t;

	// Bank controller state written by controller writes.
	typedef struct packed {
		logic [ROM_BANK_W-1:0] rom_page;
		logic [RAM_BANK_W-1:0] ram_page;
		logic                  ram_enable;
		logic                  upper_to_rom_mode;
	} bank_state_t;

endpackage

`default_nettype wire

>>> rtl/mbc1_map.sv
// Combinational decode of one bus access: controller update and address translation.
// Depends on mbc1_pkg for the item, result, configuration and state types.
`default_nettype none

module mbc1_map (
	input  mbc1_pkg::item_t       item,
	input  mbc1_pkg::cfg_t        cfg,
	input  mbc1_pkg::bank_state_t state,
	output mbc1_pkg::result_t     result,
	output mbc1_pkg::bank_state_t next_state
);

	logic [mbc1_pkg::ROM_BANK_W-1:0] rom_page_eff;
	logic [mbc1_pkg::MEM_ADDR_W-1:0] rom_phys;
	logic [mbc1_pkg::RAM_OFF_W-1:0]  ram_off;
	logic [4:0]                      low_bank;
	logic                            ram_ok;

	// Upper ROM window bank, with a zero low bank read as bank one.
	always_comb begin
		rom_page_eff = state.rom_page;
		if (state.rom_page[4:0] == 5'd0) begin
			rom_page_eff[0] = 1'b1;
		end
	end

	// Physical ROM address for a read in the ROM window.
	always_comb begin
		if (!cfg.mbc1_present) begin
			rom_phys = {6'd0, item.bus_address[14:0]};
		end else if (!item.bus_address[14]) begin
			if (state.upper_to_rom_mode) begin
				rom_phys = {7'd0, item.bus_address[13:0]};
			end else begin
				rom_phys = {state.rom_page[6:5], 5'd0, item.bus_address[13:0]};
			end
		end else begin
			rom_phys = {rom_page_eff, item.bus_address[13:0]};
		end
	end

	// RAM offset and its permission check.
	assign ram_off = {state.ram_page, item.bus_address[12:0]};
	assign ram_ok  = state.ram_enable
		&& ({3'd0, ram_off} < cfg.ram_size_bytes)
		&& !(item.action && !cfg.mbc1_present);

	assign low_bank = (item.bus_data[4:0] == 5'd0) ? 5'd1 : item.bus_data[4:0];

	// Result selection and controller register update.
	always_comb begin
		result      = '0;
		result.target = mbc1_pkg::TGT_NONE;
		next_state  = state;
		if (!item.bus_address[15]) begin
			if (item.action) begin
				if (cfg.mbc1_present) begin
					unique case (mbc1_pkg::ctl_region_t'(item.bus_address[14:13]))
						mbc1_pkg::CTL_RAM_ENABLE: begin
							next_state.ram_enable = (item.bus_data[3:0] == mbc1_pkg::RAM_ENABLE_KEY);
						end
						mbc1_pkg::CTL_ROM_BANK: begin
							next_state.rom_page[4:0] = low_bank;
						end
						mbc1_pkg::CTL_UPPER_BITS: begin
							if (state.upper_to_rom_mode) begin
								next_state.rom_page[6:5] = item.bus_data[1:0];
							end else begin
								next_state.ram_page = item.bus_data[1:0];
							end
						end
						mbc1_pkg::CTL_MODE: begin
							next_state.upper_to_rom_mode = item.bus_data[0];
						end
						default: begin
							next_state = state;
						end
					endcase
				end
			end else if ({3'd0, rom_phys} < cfg.rom_size_bytes) begin
				result.target      = mbc1_pkg::TGT_ROM;
				result.mem_address = rom_phys;
			end
		end else if (item.bus_address[15:13] == 3'b101 && ram_ok) begin
			result.target      = mbc1_pkg::TGT_RAM;
			result.mem_address = {6'd0, ram_off};
			if (item.action) begin
				result.ram_write  = 1'b1;
				result.write_byte = item.bus_data;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/mbc1_bank_address_mapper_unit.sv
// Top level of the MBC1 bank address mapper: APB registers, input and result stages.
// Depends on mbc1_pkg and instantiates mbc1_map.
//
// Use: each CPU access to the cartridge ROM window (0000-7FFF) or external RAM
// window (A000-BFFF) is offered as one beat on the input channel (in_valid,
// in_ready; action, bus_address, bus_data). Every beat yields exactly one result
// beat on the output channel (out_valid, out_ready; target, mem_address,
// ram_write, write_byte). Writes to the ROM window on an MBC1 cartridge update
// the bank registers and report target none.
// From acceptance, the access sits in the input register and is then decoded into
// the result register, which offers it on the output channel. Throughput is one
// beat per cycle while the receiver does not stall; the bank registers update as an access
// leaves the input register, so the next access already sees the new banks.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more beat before in_ready falls.
// The APB port holds mbc1_present at 0x0, rom_size_bytes at 0x4 and ram_size_bytes
// at 0x8. Write it only while the block is idle; the block does not enforce this.
// Reset clears both stages, the bank registers and RAM enable, and returns the
// configuration to flat ROM of 32 KiB with no RAM.
`default_nettype none

module mbc1_bank_address_mapper_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [3:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// Input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [mbc1_pkg::BUS_ADDR_W-1:0]  bus_address,
	input  logic [mbc1_pkg::BYTE_W-1:0]      bus_data,
	// Output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       target,
	output logic [mbc1_pkg::MEM_ADDR_W-1:0]  mem_address,
	output logic                             ram_write,
	output logic [mbc1_pkg::BYTE_W-1:0]      write_byte
);

	mbc1_pkg::cfg_t        cfg_q;
	mbc1_pkg::bank_state_t bank_q;
	mbc1_pkg::bank_state_t bank_next;
	mbc1_pkg::item_t       item_s1;
	mbc1_pkg::result_t     res_comb;
	mbc1_pkg::result_t     res_s2;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  adv_s1;
	logic                  cfg_wr;
	mbc1_pkg::reg_index_t  reg_idx;

	// APB register file.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = mbc1_pkg::reg_index_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mbc1_present   <= 1'b0;
			cfg_q.rom_size_bytes <= 24'd32768;
			cfg_q.ram_size_bytes <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				mbc1_pkg::REG_MBC1_PRESENT: cfg_q.mbc1_present   <= pwdata[0];
				mbc1_pkg::REG_ROM_SIZE:     cfg_q.rom_size_bytes <= pwdata[mbc1_pkg::ROM_SIZE_W-1:0];
				mbc1_pkg::REG_RAM_SIZE:     cfg_q.ram_size_bytes <= pwdata[mbc1_pkg::RAM_SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			mbc1_pkg::REG_MBC1_PRESENT: prdata = {31'd0, cfg_q.mbc1_present};
			mbc1_pkg::REG_ROM_SIZE:     prdata = {8'd0, cfg_q.rom_size_bytes};
			mbc1_pkg::REG_RAM_SIZE:     prdata = {14'd0, cfg_q.ram_size_bytes};
			default:                    prdata = '0;
		endcase
	end

	// Stage handshakes: the input register moves on whenever the result register is free.
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.action      <= action;
			item_s1.bus_address <= bus_address;
			item_s1.bus_data    <= bus_data;
		end
	end

	// Decode of the access held in the input register.
	mbc1_map u_map (
		.item       (item_s1),
		.cfg        (cfg_q),
		.state      (bank_q),
		.result     (res_comb),
		.next_state (bank_next)
	);

	// Bank controller state, updated as each access leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= '0;
		end else if (adv_s1) begin
			bank_q <= bank_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid   = valid_s2;
	assign target      = res_s2.target;
	assign mem_address = res_s2.mem_address;
	assign ram_write   = res_s2.ram_write;
	assign write_byte  = res_s2.write_byte;

`ifndef SYNTHESIS
	// A RAM store is only ever issued towards cartridge RAM.
	a_write_is_ram: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ram_write |-> res_s2.target == mbc1_pkg::TGT_RAM)
		else $error("RAM write issued without RAM target");

	// An access that selects nothing carries an all-zero payload.
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_s2.target == mbc1_pkg::TGT_NONE |->
		mem_address == '0 && !ram_write && write_byte == '0)
		else $error("Open-bus result with non-zero payload");

	// A RAM address always lies inside the fitted RAM.
	a_ram_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_s2.target == mbc1_pkg::TGT_RAM |->
		{3'd0, mem_address[mbc1_pkg::RAM_OFF_W-1:0]} < cfg_q.ram_size_bytes)
		else $error("RAM address beyond configured size");

	// The input side stalls only when both stages are full and the receiver is stalling.
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("Input stalled with room in the pipeline");

	// Bank state changes only as an access leaves the input register.
	a_bank_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(bank_q))
		else $error("Bank state changed without an access");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for mbc1_bank_address_mapper_unit: bus accesses in, translated beats out.
// Depends on mbc1_pkg and the RTL top level; expected beats come from typed rows or a predictor.

module testbench;

	localparam int          ITEMS_PER_PHASE = 240;
	localparam int          PHASES          = 7;
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int          DRAIN_CYCLES    = 4;

	// Cartridge settings per random phase; phase 5 draws its sizes at random.
	localparam logic        PH_MBC1 [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
	localparam int unsigned PH_ROM [PHASES]  = '{32'h80_0000, 32'h8000, 32'h8_0000, 32'h2_0000,
		32'h20_0000, 32'h8000, 32'h80_0000};
	localparam int unsigned PH_RAM [PHASES]  = '{32'h2_0000, 32'h0, 32'h2000, 32'h8000,
		32'h8000, 32'h0, 32'h2_0000};

	// One row of the directed sequence; want_* is only meaningful when typed is set.
	typedef struct packed {
		logic                            typed;
		logic                            act;
		logic [mbc1_pkg::BUS_ADDR_W-1:0] addr;
		logic [mbc1_pkg::BYTE_W-1:0]     data;
		mbc1_pkg::target_t               want_target;
		logic [mbc1_pkg::MEM_ADDR_W-1:0] want_address;
		logic                            want_write;
		logic [mbc1_pkg::BYTE_W-1:0]     want_byte;
	} access_row_t;

	// The first rows run on the reset configuration (flat ROM, no RAM); the cartridge
	// is then switched to MBC1 with the largest ROM and RAM.
	localparam int DIR_FLAT_ROWS = 8;
	localparam int DIR_ROWS      = 26;
	localparam access_row_t DIRECTED [DIR_ROWS] = '{
		'{1'b1, 1'b0, 16'h0000, 8'h00, mbc1_pkg::TGT_ROM,  21'h0000, 1'b0, 8'h00},
		'{1'b1, 1'b0, 16'h7FFF, 8'hFF, mbc1_pkg::TGT_ROM,  21'h7FFF, 1'b0, 8'h00},
		'{1'b1, 1'b1, 16'h0000, 8'h0A, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b0, 16'hA000, 8'h00, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b1, 16'hBFFF, 8'h5A, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b0, 16'h8000, 8'hFF, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b0, 16'hFFFF, 8'h00, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b1, 16'hC000, 8'hFF, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b1, 16'h0000, 8'h0A, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b1, 16'hA000, 8'h00, mbc1_pkg::TGT_RAM,  21'h0000, 1'b1, 8'h00},
		'{1'b1, 1'b1, 16'hBFFF, 8'hFF, mbc1_pkg::TGT_RAM,  21'h1FFF, 1'b1, 8'hFF},
		'{1'b1, 1'b1, 16'h2000, 8'h00, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b0, 16'h4000, 8'h00, mbc1_pkg::TGT_ROM,  21'h4000, 1'b0, 8'h00},
		'{1'b1, 1'b1, 16'h3FFF, 8'h1F, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b0, 1'b0, 16'h7FFF, 8'h00, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b1, 16'h6000, 8'h01, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b1, 16'h4000, 8'h03, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b0, 1'b0, 16'h7FFF, 8'h00, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b0, 1'b0, 16'h0000, 8'h00, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b1, 16'h7FFF, 8'hFE, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b0, 1'b0, 16'h3FFF, 8'h00, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b1, 16'h5FFF, 8'h02, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b0, 1'b0, 16'hA123, 8'h00, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b1, 16'h1FFF, 8'h00, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b1, 1'b0, 16'hBFFF, 8'h00, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00},
		'{1'b0, 1'b1, 16'h2000, 8'h20, mbc1_pkg::TGT_NONE, 21'h0,    1'b0, 8'h00}
	};

	// Clock, reset and the signals driven into the block.
	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [3:0]                      paddr = '0;
	logic [31:0]                     pwdata = '0;
	logic [31:0]                     prdata;
	logic                            pready;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic                            action = 1'b0;
	logic [mbc1_pkg::BUS_ADDR_W-1:0] bus_address = '0;
	logic [mbc1_pkg::BYTE_W-1:0]     bus_data = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [1:0]                      target;
	logic [mbc1_pkg::MEM_ADDR_W-1:0] mem_address;
	logic                            ram_write;
	logic [mbc1_pkg::BYTE_W-1:0]     write_byte;

	// Predicted cartridge configuration and bank controller state.
	logic                            mbc1_fitted = 1'b0;
	logic [mbc1_pkg::ROM_SIZE_W-1:0] cart_rom_size = 24'h8000;
	logic [mbc1_pkg::RAM_SIZE_W-1:0] cart_ram_size = '0;
	logic [mbc1_pkg::ROM_BANK_W-1:0] bank_rom = '0;
	logic [mbc1_pkg::RAM_BANK_W-1:0] bank_ram = '0;
	logic                            ram_on = 1'b0;
	logic                            upper_to_rom = 1'b0;

	mbc1_pkg::result_t pending_results[$];
	int                fail_count = 0;
	int unsigned       send_idle_pct = 0;
	int unsigned       recv_idle_pct = 0;
	int unsigned       cycles = 0;

	mbc1_bank_address_mapper_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.bus_address (bus_address),
		.bus_data    (bus_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.target      (target),
		.mem_address (mem_address),
		.ram_write   (ram_write),
		.write_byte  (write_byte)
	);

	always #10 clk = ~clk;

	// Translate one access as the cartridge would, updating the bank state on
	// controller writes.
	function automatic mbc1_pkg::result_t map_access(input mbc1_pkg::item_t acc);
		mbc1_pkg::result_t               r;
		logic [23:0]                     phys;
		logic [mbc1_pkg::ROM_BANK_W-1:0] bank;
		logic [mbc1_pkg::RAM_OFF_W-1:0]  ram_off;
		r = '0;
		r.target = mbc1_pkg::TGT_NONE;
		if (!acc.bus_address[15]) begin
			if (acc.action) begin
				if (mbc1_fitted) begin
					case (mbc1_pkg::ctl_region_t'(acc.bus_address[14:13]))
						mbc1_pkg::CTL_RAM_ENABLE: begin
							ram_on = (acc.bus_data[3:0] == mbc1_pkg::RAM_ENABLE_KEY);
						end
						mbc1_pkg::CTL_ROM_BANK: begin
							// A low bank of zero is taken as bank one.
							bank_rom[4:0] = (acc.bus_data[4:0] == 5'd0) ? 5'd1 :
								acc.bus_data[4:0];
						end
						mbc1_pkg::CTL_UPPER_BITS: begin
							if (upper_to_rom)
								bank_rom[6:5] = acc.bus_data[1:0];
							else
								bank_ram = acc.bus_data[1:0];
						end
						default: upper_to_rom = acc.bus_data[0];
					endcase
				end
			end else begin
				if (!mbc1_fitted)
					phys = {8'd0, acc.bus_address};
				else if (!acc.bus_address[14])
					phys = upper_to_rom ? {10'd0, acc.bus_address[13:0]} :
						{3'd0, bank_rom[6:5], 5'd0, acc.bus_address[13:0]};
				else begin
					bank = bank_rom;
					if (bank[4:0] == 5'd0)
						bank[0] = 1'b1;
					phys = {3'd0, bank, acc.bus_address[13:0]};
				end
				if (phys < cart_rom_size) begin
					r.target = mbc1_pkg::TGT_ROM;
					r.mem_address = phys[mbc1_pkg::MEM_ADDR_W-1:0];
				end
			end
		end else if (acc.bus_address[15:13] == 3'b101) begin
			ram_off = {bank_ram, acc.bus_address[12:0]};
			// RAM writes on a flat cartridge select nothing; reads use the kept bank state.
			if (ram_on && cart_ram_size != '0 && {3'd0, ram_off} < cart_ram_size &&
				!(acc.action && !mbc1_fitted)) begin
				r.target = mbc1_pkg::TGT_RAM;
				r.mem_address = {6'd0, ram_off};
				r.ram_write = acc.action;
				r.write_byte = acc.action ? acc.bus_data : 8'h00;
			end
		end
		return r;
	endfunction

	// Random access, weighted towards sequences that open up the banked paths.
	function automatic mbc1_pkg::item_t random_access();
		mbc1_pkg::item_t a;
		int unsigned     pick;
		a.action = 1'($urandom_range(1, 0));
		a.bus_address = 16'($urandom);
		a.bus_data = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 15) begin
			a.action = 1'b1;
			a.bus_address[15] = 1'b0;
			if (a.bus_address[14:13] == mbc1_pkg::CTL_RAM_ENABLE && $urandom_range(3) != 0)
				a.bus_data[3:0] = mbc1_pkg::RAM_ENABLE_KEY;
		end else if (pick < 55) begin
			a.action = 1'b0;
			a.bus_address[15] = 1'b0;
		end else if (pick < 92) begin
			a.bus_address[15:13] = 3'b101;
		end
		return a;
	endfunction

	// One APB transfer, after which the bus returns to idle; called and returns at a falling edge.
	task automatic apb_transfer(input logic wr, input mbc1_pkg::reg_index_t idx,
		input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Write a register, mirror it in the predictor and read it back unless it is unused.
	task automatic set_register(input mbc1_pkg::reg_index_t idx, input logic [31:0] value);
		logic [31:0] held;
		logic [31:0] readback;
		apb_transfer(1'b1, idx, value, readback);
		case (idx)
			mbc1_pkg::REG_MBC1_PRESENT: mbc1_fitted = value[0];
			mbc1_pkg::REG_ROM_SIZE:     cart_rom_size = value[mbc1_pkg::ROM_SIZE_W-1:0];
			mbc1_pkg::REG_RAM_SIZE:     cart_ram_size = value[mbc1_pkg::RAM_SIZE_W-1:0];
			default: ;
		endcase
		if (idx != mbc1_pkg::REG_UNUSED) begin
			held = (idx == mbc1_pkg::REG_MBC1_PRESENT) ? {31'd0, mbc1_fitted} :
				(idx == mbc1_pkg::REG_ROM_SIZE) ? {8'd0, cart_rom_size} : {14'd0, cart_ram_size};
			apb_transfer(1'b0, idx, 32'd0, readback);
			if (readback !== held) begin
				$error("prdata: expected %0h, actual %0h", held, readback);
				fail_count++;
			end
		end
	endtask

	// Offer one beat, wait for it to be taken and queue its expected result.
	task automatic send_access(input mbc1_pkg::item_t acc, input logic typed,
		input mbc1_pkg::result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= acc.action;
		bus_address <= acc.bus_address;
		bus_data <= acc.bus_data;
		do @(posedge clk); while (!in_ready);
		if (typed) begin
			void'(map_access(acc));
			pending_results.push_back(want);
		end else begin
			pending_results.push_back(map_access(acc));
		end
		@(negedge clk);
	endtask

	// Stop offering beats and let every outstanding result drain out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// The receiver stalls at random, at the rate of the current phase.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare each delivered beat with the oldest expectation.
	always @(posedge clk) begin
		mbc1_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (target !== want.target) begin
					$error("target: expected %0d, actual %0d", want.target, target);
					fail_count++;
				end
				if (mem_address !== want.mem_address) begin
					$error("mem_address: expected %0h, actual %0h", want.mem_address, mem_address);
					fail_count++;
				end
				if (ram_write !== want.ram_write) begin
					$error("ram_write: expected %0d, actual %0d", want.ram_write, ram_write);
					fail_count++;
				end
				if (write_byte !== want.write_byte) begin
					$error("write_byte: expected %0h, actual %0h", want.write_byte, write_byte);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("mbc1_bank_address_mapper_unit regression: fail");
		$finish;
	end

	// Stimulus: directed rows, then random phases over several cartridge settings.
	initial begin
		mbc1_pkg::item_t   acc;
		mbc1_pkg::result_t want;
		access_row_t       row;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 26;
		recv_idle_pct = 60;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_FLAT_ROWS) begin
				// Junk above each register's width must be dropped.
				wait_idle();
				set_register(mbc1_pkg::REG_MBC1_PRESENT, 32'h8000_0001);
				set_register(mbc1_pkg::REG_ROM_SIZE, 32'hAB80_0000);
				set_register(mbc1_pkg::REG_RAM_SIZE, 32'hFFFE_0000);
				set_register(mbc1_pkg::REG_UNUSED, 32'hFFFF_FFFF);
			end
			row = DIRECTED[i];
			acc.action = row.act;
			acc.bus_address = row.addr;
			acc.bus_data = row.data;
			want.target = row.want_target;
			want.mem_address = row.want_address;
			want.ram_write = row.want_write;
			want.write_byte = row.want_byte;
			send_access(acc, row.typed, want);
		end
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			set_register(mbc1_pkg::REG_MBC1_PRESENT, {31'd0, PH_MBC1[ph]});
			if (ph == 5) begin
				set_register(mbc1_pkg::REG_ROM_SIZE, $urandom_range(32'h80_0000, 32'h8000));
				set_register(mbc1_pkg::REG_RAM_SIZE, $urandom_range(32'h2_0000, 0));
			end else begin
				set_register(mbc1_pkg::REG_ROM_SIZE, PH_ROM[ph]);
				set_register(mbc1_pkg::REG_RAM_SIZE, PH_RAM[ph]);
			end
			send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 60 : 0;
			recv_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 26 : 0;
			want = '0;
			repeat (ITEMS_PER_PHASE) send_access(random_access(), 1'b0, want);
		end
		wait_idle();
		if (fail_count == 0)
			$display("mbc1_bank_address_mapper_unit regression: pass");
		else
			$display("mbc1_bank_address_mapper_unit regression: fail");
		$finish;
	end

endmodule
